>>> rtl/core/eposp_pkg.sv
// Shared types and constants for the edge pixel orientation splitter.
package eposp_pkg;

   localparam int CFG_W   = 11;
   localparam int PIX_W   = 8;
   localparam int MARK_W  = 8;
   localparam int FLAG_W  = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [CFG_W-1:0]  CFG_SIZE_RESET = 11'd1024;
   localparam logic [MARK_W-1:0] MARK_ON  = 8'hFF;
   localparam logic [MARK_W-1:0] MARK_OFF = 8'h00;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      logic [MARK_W-1:0] horizontal_mark;
      logic [MARK_W-1:0] vertical_mark;
      logic              frame_end;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } push_type;

endpackage

>>> rtl/core/eposp_if.sv
// Request, response and register write channel interfaces.
interface eposp_req_if import eposp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             cmd;
   logic [PIX_W-1:0] pixel;

   modport source (output valid, output cmd, output pixel, input ready);
   modport sink   (input valid, input cmd, input pixel, output ready);
endinterface

interface eposp_rsp_if import eposp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MARK_W-1:0] horizontal_mark;
   logic [MARK_W-1:0] vertical_mark;
   logic              frame_end;

   modport source (output valid, output horizontal_mark, output vertical_mark,
                   output frame_end, input ready);
   modport sink   (input valid, input horizontal_mark, input vertical_mark,
                   input frame_end, output ready);
endinterface

interface eposp_csr_if import eposp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/eposp_flag_ram.sv
// Line flag RAM: one write port, two registered read ports, write-first forwarding.
module eposp_flag_ram import eposp_pkg::*; #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr0,
   input  logic [AW-1:0]     rd_addr1,
   output logic [FLAG_W-1:0] rd_data0,
   output logic [FLAG_W-1:0] rd_data1,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [FLAG_W-1:0] wr_data
);

   logic [FLAG_W-1:0] mem [DEPTH];
   logic [FLAG_W-1:0] rd_data0_ff;
   logic [FLAG_W-1:0] rd_data1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data0_ff <= (wr_en && (wr_addr == rd_addr0)) ? wr_data : mem[rd_addr0];
         rd_data1_ff <= (wr_en && (wr_addr == rd_addr1)) ? wr_data : mem[rd_addr1];
      end
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

>>> rtl/core/eposp_scan.sv
// Raster scan control: size registers, counters, neighbor window and mark logic.
module eposp_scan import eposp_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int AW         = 10
) (
   input  logic              clock,
   input  logic              reset,
   eposp_req_if.sink         req_bus,
   eposp_csr_if.sink         csr_bus,
   input  logic              in_ready,
   output logic              rd_en,
   output logic [AW-1:0]     rd_addr0,
   output logic [AW-1:0]     rd_addr1,
   input  logic [FLAG_W-1:0] rd_data0,
   input  logic [FLAG_W-1:0] rd_data1,
   output logic              wr_en,
   output logic [AW-1:0]     wr_addr,
   output logic [FLAG_W-1:0] wr_data,
   output push_type          push
);

   localparam int WVW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
   localparam int HVW = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
   localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   logic [CFG_W-1:0] width_ff;
   logic [CFG_W-1:0] height_ff;
   logic [AW-1:0]    col_ff,   col_in;
   logic [RW-1:0]    row_ff,   row_in;
   logic [WVW-1:0]   pend_ff,  pend_in;
   logic             drain_ff, drain_in;
   logic             win_ff,   win_in;

   logic [WVW-1:0] w_raw, w_eff, col_next_x;
   logic [HVW-1:0] h_raw, h_eff, row_next_x;
   logic           accept, own, left, right, below, last_col, last_row, drain_last;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = in_ready;
   assign accept        = req_bus.valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_SIZE_RESET;
         height_ff <= CFG_SIZE_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_bus.data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // size clamp: zero acts as one, oversize acts as the maximum
   always_comb begin
      w_raw = WVW'(width_ff);
      h_raw = HVW'(height_ff);
      if (w_raw == '0) begin
         w_eff = WVW'(1);
      end else if (w_raw > WVW'(MAX_WIDTH)) begin
         w_eff = WVW'(MAX_WIDTH);
      end else begin
         w_eff = w_raw;
      end
      if (h_raw == '0) begin
         h_eff = HVW'(1);
      end else if (h_raw > HVW'(MAX_HEIGHT)) begin
         h_eff = HVW'(MAX_HEIGHT);
      end else begin
         h_eff = h_raw;
      end
   end

   assign own        = rd_data0[0];
   assign col_next_x = WVW'(col_ff) + WVW'(1);
   assign row_next_x = HVW'(row_ff) + HVW'(1);
   assign last_col   = (col_next_x >= w_eff);
   assign last_row   = (row_next_x >= h_eff);
   assign left       = (col_ff != '0) && win_ff;
   assign right      = !last_col && rd_data1[0];
   assign below      = (req_bus.pixel != '0);
   assign drain_last = (pend_ff <= WVW'(1));

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      pend_in  = pend_ff;
      drain_in = drain_ff;
      win_in   = win_ff;
      push     = '0;
      wr_en    = 1'b0;
      wr_addr  = col_ff;
      wr_data  = {own, below};
      if (accept) begin
         if (!drain_ff) begin
            if (req_bus.cmd == CMD_PIXEL) begin
               if (row_ff != '0) begin
                  push.valid = 1'b1;
                  push.payload.horizontal_mark = (own && (left || right)) ? MARK_ON : MARK_OFF;
                  push.payload.vertical_mark =
                     (own && (((HVW'(row_ff) >= HVW'(2)) && rd_data0[1]) || below)) ?
                     MARK_ON : MARK_OFF;
                  push.payload.frame_end = 1'b0;
               end
               wr_en  = 1'b1;
               win_in = own;
               if (last_col) begin
                  col_in = '0;
                  win_in = 1'b0;
                  if (last_row) begin
                     drain_in = 1'b1;
                     pend_in  = w_eff;
                  end else begin
                     row_in = row_ff + RW'(1);
                  end
               end else begin
                  col_in = col_ff + AW'(1);
               end
            end
         end else if (req_bus.cmd == CMD_DRAIN) begin
            push.valid = 1'b1;
            push.payload.horizontal_mark = (own && (left || right)) ? MARK_ON : MARK_OFF;
            push.payload.vertical_mark =
               (own && (row_ff != '0) && rd_data0[1]) ? MARK_ON : MARK_OFF;
            push.payload.frame_end = drain_last;
            win_in = own;
            if (drain_last) begin
               pend_in  = '0;
               col_in   = '0;
               row_in   = '0;
               win_in   = 1'b0;
               drain_in = 1'b0;
            end else begin
               pend_in = pend_ff - WVW'(1);
               col_in  = col_ff + AW'(1);
            end
         end
      end
   end

   // prefetch the flags of the next column and its right neighbor
   assign rd_en    = accept;
   assign rd_addr0 = col_in;
   assign rd_addr1 = col_in + AW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         pend_ff  <= '0;
         drain_ff <= 1'b0;
         win_ff   <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         pend_ff  <= pend_in;
         drain_ff <= drain_in;
         win_ff   <= win_in;
      end
   end

endmodule

>>> rtl/core/eposp_out_buf.sv
// Response output register with skid slot.
module eposp_out_buf import eposp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  push_type    push,
   output logic        in_ready,
   eposp_rsp_if.source rsp_bus
);

   logic            out_valid_ff,  out_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type out_data_ff,   out_data_in;
   rsp_payload_type skid_data_ff,  skid_data_in;
   logic            pop;

   assign pop      = out_valid_ff && rsp_bus.ready;
   assign in_ready = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || pop) begin
         out_valid_in = push.valid;
         out_data_in  = push.payload;
      end else if (push.valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.horizontal_mark = out_data_ff.horizontal_mark;
   assign rsp_bus.vertical_mark   = out_data_ff.vertical_mark;
   assign rsp_bus.frame_end       = out_data_ff.frame_end;

endmodule

>>> rtl/core/edge_pixel_orientation_split_top.sv
// Edge pixel orientation splitter, top level.
// Takes one edge pixel per clock in raster order and returns, for each pixel,
// a horizontal and a vertical mark (255 on an edge pixel with an edge neighbor
// along that axis, else 0) one row later, once its lower neighbor has arrived;
// pixel requests of the first row return nothing. After the last pixel of a
// frame, send image_width drain requests (cmd = 1) to flush the last row; the
// final result carries frame_end. Throughput is one request per clock with no
// bubbles while the skid slot is free: the line flag RAM is read for the next
// column and its right neighbor while the current column is written back, with
// write-first forwarding on collisions. A result is registered into the response
// register when its request is accepted, or into the skid slot while that
// register is stalled; the two let requests continue while a result waits. Write
// the size registers only between frames.
module edge_pixel_orientation_split_top import eposp_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   eposp_req_if.sink   req_bus,
   eposp_rsp_if.source rsp_bus,
   eposp_csr_if.sink   csr_bus
);

   localparam int AW = $clog2(MAX_WIDTH);

   logic              in_ready;
   logic              rd_en, wr_en;
   logic [AW-1:0]     rd_addr0, rd_addr1, wr_addr;
   logic [FLAG_W-1:0] rd_data0, rd_data1, wr_data;
   push_type          push;

   eposp_scan #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .AW         (AW)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .csr_bus  (csr_bus),
      .in_ready (in_ready),
      .rd_en    (rd_en),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .push     (push)
   );

   eposp_flag_ram #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
   ) u_ram (
      .clock    (clock),
      .rd_en    (rd_en),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data)
   );

   eposp_out_buf u_out (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .in_ready (in_ready),
      .rsp_bus  (rsp_bus)
   );

endmodule

>>> rtl/core/eposp_checker.sv
// Port-level checker for the splitter response channel, with its bind.
module eposp_checker import eposp_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [MARK_W-1:0] rsp_horizontal_mark,
   input logic [MARK_W-1:0] rsp_vertical_mark,
   input logic              rsp_frame_end
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_horizontal_mark) && $stable(rsp_vertical_mark) &&
         $stable(rsp_frame_end))
      else $error("response payload changed while stalled");

   a_mark_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_horizontal_mark == MARK_ON || rsp_horizontal_mark == MARK_OFF) &&
         (rsp_vertical_mark == MARK_ON || rsp_vertical_mark == MARK_OFF))
      else $error("mark value other than on or off");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind edge_pixel_orientation_split_top eposp_checker u_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_horizontal_mark (rsp_bus.horizontal_mark),
   .rsp_vertical_mark   (rsp_bus.vertical_mark),
   .rsp_frame_end       (rsp_bus.frame_end)
);
